// ----- sv/u8dv_pkg.sv -----
package u8dv_pkg;

   localparam int BYTE_W = 8;
   localparam int CP_W   = 21;
   localparam int LEN_W  = 3;
   localparam int PEND_W = 2;

   // sequence lengths
   localparam logic [LEN_W-1:0] SEQ_LEN_NONE = 3'd0;
   localparam logic [LEN_W-1:0] SEQ_LEN_1    = 3'd1;
   localparam logic [LEN_W-1:0] SEQ_LEN_2    = 3'd2;
   localparam logic [LEN_W-1:0] SEQ_LEN_3    = 3'd3;
   localparam logic [LEN_W-1:0] SEQ_LEN_4    = 3'd4;

   // smallest value each length may carry (anything lower is overlong)
   localparam logic [CP_W-1:0] CP_MIN_2 = 21'h00_0080;
   localparam logic [CP_W-1:0] CP_MIN_3 = 21'h00_0800;
   localparam logic [CP_W-1:0] CP_MIN_4 = 21'h01_0000;

   localparam logic [CP_W-1:0] CP_SURR_LO  = 21'h00_d7ff;
   localparam logic [CP_W-1:0] CP_SURR_END = 21'h00_e000;
   localparam logic [CP_W-1:0] CP_MAX      = 21'h10_ffff;
   localparam logic [CP_W-1:0] CP_NONCH_LO = 21'h00_fdd0;
   localparam logic [CP_W-1:0] CP_NONCH_HI = 21'h00_fdef;

   localparam logic [1:0] CONT_TAG = 2'b10;

   typedef enum logic [2:0] {
      LEAD_NUL,
      LEAD_ASCII,
      LEAD_CONT,
      LEAD_TWO,
      LEAD_THREE,
      LEAD_FOUR,
      LEAD_BAD
   } lead_type;

   typedef struct packed {
      logic [PEND_W-1:0] pend;
      logic [CP_W-1:0]   value;
      logic [LEN_W-1:0]  len;
      logic              failed;
   } state_type;

   typedef struct packed {
      logic [CP_W-1:0]  code_point;
      logic             point_ready;
      logic [LEN_W-1:0] point_bytes;
      logic             byte_error;
      logic             text_done;
      logic             text_valid;
   } result_type;

   function automatic lead_type classify(input logic [BYTE_W-1:0] b);
      lead_type cls;
      case (b) inside
         8'h00:         cls = LEAD_NUL;
         [8'h01:8'h7f]: cls = LEAD_ASCII;
         [8'h80:8'hbf]: cls = LEAD_CONT;
         [8'hc0:8'hdf]: cls = LEAD_TWO;
         [8'he0:8'hef]: cls = LEAD_THREE;
         [8'hf0:8'hf7]: cls = LEAD_FOUR;
         default:       cls = LEAD_BAD;
      endcase
      return cls;
   endfunction

   // surrogates, out of range and noncharacters are refused
   function automatic logic cp_allowed(input logic [CP_W-1:0] c);
      logic ok;
      if (c <= CP_SURR_LO) begin
         ok = 1'b1;
      end else if (c < CP_SURR_END || c > CP_MAX) begin
         ok = 1'b0;
      end else if (c >= CP_NONCH_LO && c <= CP_NONCH_HI) begin
         ok = 1'b0;
      end else if (c[15:1] == 15'h7fff) begin
         ok = 1'b0;
      end else begin
         ok = 1'b1;
      end
      return ok;
   endfunction

endpackage

// ----- sv/u8dv_step.sv -----
module u8dv_step
   import u8dv_pkg::*;
(
   input  state_type         cur,
   input  logic [BYTE_W-1:0] data_byte,
   input  logic              last_byte,
   output state_type         nxt,
   output result_type        res
);

   lead_type          cls;
   logic [CP_W-1:0]   acc;
   logic [PEND_W-1:0] pend_dec;
   logic [CP_W-1:0]   min_val;
   logic              err;
   logic              ready;
   logic [CP_W-1:0]   cp;
   logic [LEN_W-1:0]  nbytes;
   state_type         upd;

   assign cls      = classify(data_byte);
   assign acc      = {cur.value[CP_W-7:0], data_byte[5:0]};
   assign pend_dec = cur.pend - 2'd1;

   always_comb begin
      unique case (cur.len)
         SEQ_LEN_2: min_val = CP_MIN_2;
         SEQ_LEN_3: min_val = CP_MIN_3;
         default:   min_val = CP_MIN_4;
      endcase
   end

   always_comb begin
      upd    = cur;
      err    = 1'b0;
      ready  = 1'b0;
      cp     = '0;
      nbytes = SEQ_LEN_NONE;
      if (!cur.failed) begin
         if (cur.pend == '0) begin
            unique case (cls)
               LEAD_ASCII: begin
                  cp     = {{(CP_W-BYTE_W){1'b0}}, data_byte};
                  nbytes = SEQ_LEN_1;
                  ready  = 1'b1;
               end
               LEAD_TWO: begin
                  upd.value = {{(CP_W-5){1'b0}}, data_byte[4:0]};
                  upd.len   = SEQ_LEN_2;
                  upd.pend  = 2'd1;
               end
               LEAD_THREE: begin
                  upd.value = {{(CP_W-4){1'b0}}, data_byte[3:0]};
                  upd.len   = SEQ_LEN_3;
                  upd.pend  = 2'd2;
               end
               LEAD_FOUR: begin
                  upd.value = {{(CP_W-3){1'b0}}, data_byte[2:0]};
                  upd.len   = SEQ_LEN_4;
                  upd.pend  = 2'd3;
               end
               default: err = 1'b1;  // NUL, stray continuation, long lead
            endcase
         end else if (data_byte[7:6] != CONT_TAG) begin
            err = 1'b1;
         end else begin
            upd.value = acc;
            upd.pend  = pend_dec;
            if (pend_dec == '0) begin
               if (acc < min_val || !cp_allowed(acc)) begin
                  err = 1'b1;
               end else begin
                  cp     = acc;
                  nbytes = cur.len;
                  ready  = 1'b1;
               end
            end
         end
         // truncated at end of text
         if (!err && last_byte && upd.pend != '0) begin
            err = 1'b1;
         end
         if (err) begin
            upd.failed = 1'b1;
            upd.pend   = '0;
            upd.value  = '0;
            upd.len    = SEQ_LEN_NONE;
         end
      end
   end

   always_comb begin
      res.code_point  = cp;
      res.point_ready = ready;
      res.point_bytes = nbytes;
      res.byte_error  = err;
      res.text_done   = last_byte;
      res.text_valid  = last_byte && !upd.failed;
      nxt             = last_byte ? '0 : upd;
   end

endmodule

// ----- sv/utf8_decode_validate.sv -----
// UTF-8 decoder and validator.
// req channel: one text byte per transaction in req_tdata, req_tlast on the
//   final byte of a text. rsp channel: one result transaction per byte, with
//   the decoded code point when that byte completes a valid sequence,
//   byte_error on the byte that first breaks the text, and on the final
//   byte rsp_tlast plus text_valid for the text as a whole.
// After an error the rest of the text yields empty results until its final
//   byte; the final byte always clears the decoder for the next text.
// Path: the input register, then the decode step into the result register.
//   Throughput: one byte per cycle while rsp_tready is high; the decode
//   state (pend, value, len, failed) is updated by shallow logic, so each
//   byte can follow the previous one directly.
// Stall: while rsp_tready is low the result register holds, one more byte
//   is taken into the input register, then req_tready drops.
// Reset: synchronous, active high; clears both stages and the decode state
//   so the next byte starts a new text. No clearing pass.
module utf8_decode_validate
   import u8dv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [20:0] code_point, [21] point_ready, [24:22] point_bytes,
   // [25] byte_error, [26] text_valid, [31:27] zero
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast    // text_done
);

   // input stage
   logic              in_vld_ff, in_vld_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_last_ff;

   // decode state
   state_type st_ff, st_in;

   // result stage
   logic       out_vld_ff, out_vld_in;
   result_type out_ff, step_res;

   logic out_adv;   // result register may load
   logic step_go;   // a byte passes through the decode step

   assign out_adv    = !out_vld_ff || rsp_tready;
   assign step_go    = in_vld_ff && out_adv;
   assign req_tready = !in_vld_ff || out_adv;

   u8dv_step u_step (
      .cur       (st_ff),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .nxt       (st_in),
      .res       (step_res)
   );

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_tready) begin
         in_vld_in = req_tvalid;
      end
      out_vld_in = out_vld_ff;
      if (out_adv) begin
         out_vld_in = in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         st_ff      <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (step_go) begin
            st_ff <= st_in;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (step_go) begin
         out_ff <= step_res;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tlast  = out_ff.text_done;
   assign rsp_tdata  = {5'd0, out_ff.text_valid, out_ff.byte_error,
                        out_ff.point_bytes, out_ff.point_ready, out_ff.code_point};

   // a failed text holds no partial sequence
   a_failed_idle: assert property (@(posedge clock) disable iff (reset)
      st_ff.failed |-> (st_ff.pend == '0 && st_ff.len == SEQ_LEN_NONE))
      else $error("failed text still holds a partial sequence");

   // the final byte leaves the decoder clear
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (step_go && in_last_ff) |=> (st_ff == '0))
      else $error("decode state not cleared after final byte");

   // a code point and an error never come together
   a_ready_xor_err: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(out_ff.point_ready && out_ff.byte_error))
      else $error("code point delivered on an error byte");

   // a delivered code point is in range with a real length
   a_point_sane: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_ff.point_ready) |->
         (out_ff.code_point <= CP_MAX && out_ff.point_bytes != SEQ_LEN_NONE))
      else $error("bad code point or length");

   // text_valid only on the final byte
   a_valid_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && out_ff.text_valid) |-> out_ff.text_done)
      else $error("text_valid outside the final byte");

endmodule
